### rtl/ljd_pkg.sv
`timescale 1ns / 1ps

package ljd_pkg;

    localparam int TIME_W  = 32;
    localparam int RATE_W  = 7;
    localparam int UNITS_W = 7;
    localparam int SEL_W   = 4;
    localparam int ACT_W   = 5;
    localparam int PROD_W  = RATE_W + UNITS_W;

    localparam logic [RATE_W-1:0] RATE_MIN   = RATE_W'(1);
    localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(100);
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1);
    localparam logic [TIME_W-1:0] TIME_MAX   = '1;

    typedef enum logic
    {
        OP_SET_RATE = 1'b0,
        OP_DISPATCH = 1'b1
    } op_t;

    typedef struct packed
    {
        logic [0:0]         operation;
        logic [SEL_W-1:0]   server_select;
        logic [RATE_W-1:0]  unit_rate;
        logic [UNITS_W-1:0] job_units;
    } in_item_t;

    typedef struct packed
    {
        logic [SEL_W-1:0]  chosen_server;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] makespan;
    } out_item_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RATE,
        ST_MUL,
        ST_ADD,
        ST_PUSH
    } state_t;

endpackage

### rtl/least_loaded_job_dispatcher.sv
`timescale 1ns / 1ps

// Greedy job dispatcher for MAX_SERVERS servers of differing speed. A set-rate item
// (rates 1..100, others dropped) is taken in the idle state and gives no result. A dispatch
// item scans the first active_servers servers, with active_servers clamped to
// 1..MAX_SERVERS, then steps through drain, rate, multiply, add and push to a result
// in the output register; only then does the block return to idle for the next item.
// The free-time memory is read one server per cycle during the minimum search (lowest
// index wins ties), then the chosen server's rate is read, the job size is multiplied
// by it, and the sum is saturated, written back and folded into the makespan. The
// output register lets the next item be accepted while a result waits; a second
// dispatch then holds in its last step until that result is taken. After reset a
// clearing pass over all MAX_SERVERS entries sets every rate to 1 and every free
// time to 0; no item is accepted during it, while configuration writes are always
// taken.
module least_loaded_job_dispatcher #(
    parameter int MAX_SERVERS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ljd_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ljd_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         cfg_data
);

    import ljd_pkg::*;

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam logic [IDX_W-1:0] LAST_SERVER = IDX_W'(MAX_SERVERS - 1);

    // per-server stores
    logic [RATE_W-1:0] rate_mem [MAX_SERVERS];
    logic [TIME_W-1:0] free_mem [MAX_SERVERS];

    state_t             state_reg, state_next;
    logic [ACT_W-1:0]   active_reg;
    logic [IDX_W-1:0]   clr_idx_reg;
    logic [IDX_W-1:0]   scan_idx_reg;
    logic [IDX_W-1:0]   last_idx_reg;
    logic               cmp_vld_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic [TIME_W-1:0]  free_rd_reg;
    logic [RATE_W-1:0]  rate_rd_reg;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]  best_time_reg, best_time_next;
    logic [UNITS_W-1:0] units_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [TIME_W-1:0]  finish_reg;
    logic [TIME_W-1:0]  makespan_reg, makespan_next;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic               in_accept;
    logic               push;
    logic               rate_we;
    logic [IDX_W-1:0]   rate_waddr;
    logic [RATE_W-1:0]  rate_wdata;
    logic               free_we;
    logic [IDX_W-1:0]   free_waddr;
    logic [TIME_W-1:0]  free_wdata;
    logic [31:0]        sel_ext;
    logic [31:0]        best_ext;
    logic [31:0]        act_eff;
    logic               rate_ok;
    logic [TIME_W:0]    sum;
    logic [TIME_W-1:0]  finish;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign sel_ext  = 32'(in_data.server_select);
    assign best_ext = 32'(best_idx_reg);
    assign rate_ok  = (in_data.unit_rate >= RATE_MIN) && (in_data.unit_rate <= RATE_MAX)
                      && (sel_ext < 32'(MAX_SERVERS));

    // active count clamped to 1..MAX_SERVERS
    always_comb
    begin
        act_eff = 32'(active_reg);
        if (act_eff == 32'd0)
            act_eff = 32'd1;
        if (act_eff > 32'(MAX_SERVERS))
            act_eff = 32'(MAX_SERVERS);
    end

    // running minimum, fed one entry per cycle from the free-time memory
    always_comb
    begin
        best_idx_next  = best_idx_reg;
        best_time_next = best_time_reg;
        if (cmp_vld_reg && ((cmp_idx_reg == '0) || (free_rd_reg < best_time_reg)))
        begin
            best_idx_next  = cmp_idx_reg;
            best_time_next = free_rd_reg;
        end
    end

    assign sum    = {1'b0, best_time_reg} + (TIME_W + 1)'(prod_reg);
    assign finish = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    assign makespan_next = (finish > makespan_reg) ? finish : makespan_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == LAST_SERVER)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_accept && (op_t'(in_data.operation) == OP_DISPATCH))
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == last_idx_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_RATE;
            ST_RATE:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD:   state_next = ST_PUSH;
            ST_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready   = 1'b0;
        push       = 1'b0;
        rate_we    = 1'b0;
        rate_waddr = sel_ext[IDX_W-1:0];
        rate_wdata = in_data.unit_rate;
        free_we    = 1'b0;
        free_waddr = best_idx_reg;
        free_wdata = finish;
        unique case (state_reg)
            ST_CLEAR:
            begin
                rate_we    = 1'b1;
                rate_waddr = clr_idx_reg;
                rate_wdata = RATE_RESET;
                free_we    = 1'b1;
                free_waddr = clr_idx_reg;
                free_wdata = '0;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                rate_we  = in_valid && (op_t'(in_data.operation) == OP_SET_RATE) && rate_ok;
            end
            ST_ADD:
            begin
                free_we = 1'b1;
            end
            ST_PUSH:
            begin
                push = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (rate_we)
            rate_mem[rate_waddr] <= rate_wdata;
        rate_rd_reg <= rate_mem[best_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (free_we)
            free_mem[free_waddr] <= free_wdata;
        free_rd_reg <= free_mem[scan_idx_reg];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            active_reg    <= ACT_W'(1);
            clr_idx_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            makespan_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= (state_reg == ST_SCAN);
            if (cfg_valid && cfg_ready)
                active_reg <= cfg_data;
            if (state_reg == ST_CLEAR)
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            if (state_reg == ST_ADD)
                makespan_reg <= makespan_next;
            if (push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= scan_idx_reg;
        best_idx_reg  <= best_idx_next;
        best_time_reg <= best_time_next;
        if (in_accept)
        begin
            scan_idx_reg <= '0;
            last_idx_reg <= IDX_W'(act_eff - 32'd1);
            units_reg    <= in_data.job_units;
        end
        else if (state_reg == ST_SCAN && scan_idx_reg != last_idx_reg)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end
        if (state_reg == ST_MUL)
            prod_reg <= PROD_W'(units_reg) * PROD_W'(rate_rd_reg);
        if (state_reg == ST_ADD)
            finish_reg <= finish;
        if (push)
        begin
            out_data_reg.chosen_server <= best_ext[SEL_W-1:0];
            out_data_reg.finish_time   <= finish_reg;
            out_data_reg.makespan      <= makespan_reg;
        end
    end

    a_result_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_PUSH))
        else $error("result appeared outside the push step");

    a_makespan_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> makespan_reg >= $past(makespan_reg))
        else $error("makespan decreased");

    a_finish_within_makespan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.finish_time <= out_data_reg.makespan)
        else $error("reported finish time above makespan");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> scan_idx_reg <= last_idx_reg)
        else $error("scan index past the last active server");

    a_scan_feeds_compare: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> cmp_vld_reg && (cmp_idx_reg == last_idx_reg))
        else $error("last server not compared before rate read");

endmodule

### tb/least_loaded_job_dispatcher_tb.sv
`timescale 1ns / 1ps

module least_loaded_job_dispatcher_tb;

    import ljd_pkg::*;

    localparam int NUM_SERVERS  = 16;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_WAIT  = 30;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 300;
    localparam int PHASE_ITEMS  = 235;
    localparam int NUM_PHASES   = 8;

    class dispatch_scoreboard;
        logic [RATE_W-1:0] rate_table [NUM_SERVERS];
        logic [TIME_W-1:0] free_time [NUM_SERVERS];
        logic [TIME_W-1:0] span;
        logic [ACT_W-1:0]  active_cfg;
        out_item_t         pending_dispatches [$];
        int                errors;
        int                checked;
        int                rate_writes;

        function new();
            for (int i = 0; i < NUM_SERVERS; i++)
            begin
                rate_table[i] = RATE_RESET;
                free_time[i]  = '0;
            end
            span        = '0;
            active_cfg  = ACT_W'(1);
            errors      = 0;
            checked     = 0;
            rate_writes = 0;
        endfunction

        function void set_active(logic [ACT_W-1:0] value);
            active_cfg = value;
        endfunction

        function int pending();
            return pending_dispatches.size();
        endfunction

        function void accept_job(in_item_t it);
            int unsigned       n;
            int unsigned       best;
            logic [TIME_W:0]   sum;
            logic [TIME_W-1:0] finish;
            out_item_t         res;
            if (it.operation == OP_SET_RATE)
            begin
                if (it.unit_rate >= RATE_MIN && it.unit_rate <= RATE_MAX)
                begin
                    rate_table[it.server_select] = it.unit_rate;
                    rate_writes++;
                end
                return;
            end
            // zero counts as one, anything past the server count is clamped
            n = (active_cfg == 0) ? 1 : (active_cfg > NUM_SERVERS) ? NUM_SERVERS : active_cfg;
            best = 0;
            for (int unsigned i = 1; i < n; i++)
            begin
                if (free_time[i] < free_time[best])
                    best = i;
            end
            sum = (TIME_W+1)'(free_time[best])
                + (TIME_W+1)'(it.job_units) * (TIME_W+1)'(rate_table[best]);
            finish = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            free_time[best] = finish;
            if (finish > span)
                span = finish;
            res.chosen_server = SEL_W'(best);
            res.finish_time   = finish;
            res.makespan      = span;
            pending_dispatches.push_back(res);
        endfunction

        function void check_dispatch(out_item_t got);
            out_item_t want;
            checked++;
            if (pending_dispatches.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected: server %0d finish %0d span %0d",
                         $time, got.chosen_server, got.finish_time, got.makespan);
                return;
            end
            want = pending_dispatches.pop_front();
            if (got.chosen_server !== want.chosen_server)
            begin
                errors++;
                $display("%0t: chosen_server expected %0d actual %0d",
                         $time, want.chosen_server, got.chosen_server);
            end
            if (got.finish_time !== want.finish_time)
            begin
                errors++;
                $display("%0t: finish_time expected %0d actual %0d",
                         $time, want.finish_time, got.finish_time);
            end
            if (got.makespan !== want.makespan)
            begin
                errors++;
                $display("%0t: makespan expected %0d actual %0d",
                         $time, want.makespan, got.makespan);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    in_item_t           in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    out_item_t          out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [ACT_W-1:0]   cfg_data  = '0;

    bit                 no_idle   = 1'b0;
    bit                 hold_done = 1'b0;
    int unsigned        hold_left = 0;
    int unsigned        cycle_count = 0;
    int                 settings_used = 0;

    dispatch_scoreboard sb = new();

    least_loaded_job_dispatcher #(
        .MAX_SERVERS(NUM_SERVERS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic in_item_t make_item(op_t op, int sel, int rate, int units);
        in_item_t it;
        it.operation     = op;
        it.server_select = SEL_W'(sel);
        it.unit_rate     = RATE_W'(rate);
        it.job_units     = UNITS_W'(units);
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        it.operation     = ($urandom_range(99) < 75) ? OP_DISPATCH : OP_SET_RATE;
        it.server_select = SEL_W'($urandom_range(NUM_SERVERS - 1));
        if ($urandom_range(99) < 85)
            it.unit_rate = RATE_W'($urandom_range(100, 1));
        else if ($urandom_range(1) == 0)
            it.unit_rate = '0;
        else
            it.unit_rate = RATE_W'($urandom_range(127, 101));
        if ($urandom_range(99) < 92)
            it.job_units = UNITS_W'($urandom_range(100, 1));
        else
            it.job_units = UNITS_W'($urandom_range(127));
        return it;
    endfunction

    // valid stays up across back-to-back items, it only drops in a gap
    task automatic send_item(input in_item_t it);
        while (!no_idle && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        sb.accept_job(it);
    endtask

    // register write only once the block has drained
    task automatic write_active(input logic [ACT_W-1:0] value);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_active(value);
        settings_used++;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_dispatch(out_data);
        // one long hold-off so the block backs up into its input
        if (!hold_done && sb.checked >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= no_idle || ($urandom_range(99) >= 8);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("least_loaded_job_dispatcher: mismatch");
        $finish;
    end

    initial
    begin
        logic [ACT_W-1:0] phase_cfg [NUM_PHASES];
        in_item_t         it;
        int               counted;

        phase_cfg[0] = ACT_W'(16);
        phase_cfg[1] = ACT_W'(1);
        phase_cfg[2] = ACT_W'(0);
        phase_cfg[3] = ACT_W'(31);
        phase_cfg[4] = ACT_W'(17);
        for (int p = 5; p < NUM_PHASES; p++)
            phase_cfg[p] = ACT_W'($urandom_range(31));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        write_active(ACT_W'(4));
        send_item(make_item(OP_SET_RATE, 0, 1, 5));
        send_item(make_item(OP_SET_RATE, 1, 100, 0));
        send_item(make_item(OP_SET_RATE, 2, 0, 127));
        send_item(make_item(OP_SET_RATE, 3, 101, 1));
        send_item(make_item(OP_SET_RATE, 15, 127, 100));
        send_item(make_item(OP_SET_RATE, 3, 50, 64));
        // all free times equal: lowest index wins, zero units keeps the time
        send_item(make_item(OP_DISPATCH, 15, 127, 0));
        send_item(make_item(OP_DISPATCH, 0, 0, 127));
        send_item(make_item(OP_DISPATCH, 7, 100, 100));
        send_item(make_item(OP_DISPATCH, 8, 1, 1));
        send_item(make_item(OP_DISPATCH, 3, 55, 1));
        send_item(make_item(OP_DISPATCH, 12, 3, 0));
        send_item(make_item(OP_SET_RATE, 2, 100, 9));
        send_item(make_item(OP_DISPATCH, 5, 42, 100));
        send_item(make_item(OP_DISPATCH, 9, 99, 127));

        write_active(ACT_W'(0));
        send_item(make_item(OP_DISPATCH, 1, 1, 3));
        send_item(make_item(OP_DISPATCH, 2, 2, 100));

        write_active(ACT_W'(31));
        send_item(make_item(OP_SET_RATE, 15, 100, 2));
        send_item(make_item(OP_DISPATCH, 6, 6, 127));
        send_item(make_item(OP_DISPATCH, 4, 4, 50));
        send_item(make_item(OP_DISPATCH, 10, 10, 1));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_active(phase_cfg[p]);
            no_idle <= (p == 3);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                it = random_item();
                send_item(it);
                // dropped rate writes do not count
                if (!(it.operation == OP_SET_RATE &&
                      (it.unit_rate < RATE_MIN || it.unit_rate > RATE_MAX)))
                    counted++;
            end
        end

        in_valid <= 1'b0;
        no_idle  <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);

        $display("run covered %0d dispatch results, %0d rate writes, %0d server-count settings",
                 sb.checked, sb.rate_writes, settings_used);
        $display("largest finish time reached %0d, %0d field errors", sb.span, sb.errors);
        if (sb.errors == 0)
            $display("least_loaded_job_dispatcher: match");
        else
            $display("least_loaded_job_dispatcher: mismatch");
        $finish;
    end

endmodule
